// File: rtl/ptrr_pkg.sv
// Package for the probabilistic TRR row sampler: geometry constants,
// command and register codes, controller state type and store request.
// No dependencies.
package ptrr_pkg;

  localparam int NUM_RANKS       = 2;
  localparam int GROUPS_PER_RANK = 8;
  localparam int BANKS_PER_GROUP = 4;
  localparam int ROW_BITS        = 17;

  localparam int BANKS_PER_RANK = GROUPS_PER_RANK * BANKS_PER_GROUP;
  localparam int NUM_BANKS      = NUM_RANKS * BANKS_PER_RANK;
  localparam int IDX_W          = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int LOC_W          = (BANKS_PER_RANK > 1) ? $clog2(BANKS_PER_RANK) : 1;

  localparam logic [1:0] CMD_ACT      = 2'd0;
  localparam logic [1:0] CMD_RFM_ALL  = 2'd1;
  localparam logic [1:0] CMD_RFM_BANK = 2'd2;

  localparam logic REG_THRESHOLD   = 1'b0;
  localparam logic REG_BANK_GROUPS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ROW_BITS-1:0] wr_row;
    logic                clr_en;
    logic [IDX_W-1:0]    rd_addr;
  } store_req_t;

endpackage

// File: rtl/probabilistic_trr_row_sampler.sv
// Top level of the probabilistic TRR row sampler: command decode, sweep
// controller, pending and output registers. Uses ptrr_pkg and ptrr_store.
//
//   channel | direction | handshake              | moves
//   in_     | in        | in_valid / in_ready    | one DRAM command request
//   out_    | out       | out_valid / out_ready  | one victim-row refresh
//   cfg_    | in        | cfg_we                 | one register write
//
// Activates and ignored commands are accepted back to back.
// A per-bank refresh checks one bank; a rank-wide refresh walks every bank
// of the rank in order through the single read port of the row memory, a
// sampled bank also passing the READ state. Output stalls hold the sweep.
// Synchronous reset clears the valid flops; no clearing pass.
module probabilistic_trr_row_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_rank,
  input  logic [2:0]  in_bank_group,
  input  logic [4:0]  in_bank,
  input  logic [16:0] in_row,
  input  logic [15:0] in_random_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_vrr_rank,
  output logic [2:0]  out_vrr_bank_group,
  output logic [4:0]  out_vrr_bank,
  output logic [16:0] out_vrr_row,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);

  ptrr_pkg::state_t state_r, state_nxt;

  logic [16:0] thr_r;
  logic        grp_mode_r;

  logic                          rank_r;
  logic [ptrr_pkg::LOC_W-1:0]    loc_r, loc_nxt;
  logic [ptrr_pkg::LOC_W-1:0]    end_loc_r, end_loc_nxt;

  logic                          pend_v_r;
  logic                          pend_rank_r;
  logic [ptrr_pkg::LOC_W-1:0]    pend_loc_r;
  logic [ptrr_pkg::ROW_BITS-1:0] pend_row_r;

  logic        out_valid_r;
  logic        out_rank_r;
  logic [2:0]  out_grp_r;
  logic [4:0]  out_bank_r;
  logic [16:0] out_row_r;
  logic        out_last_r;

  ptrr_pkg::store_req_t          store_req;
  logic                          rd_valid;
  logic [ptrr_pkg::ROW_BITS-1:0] rd_row;

  logic        accept;
  logic        rank_ok, addr_ok, draw_hit;
  logic [31:0] loc_in, flat_in, flat_cur, row_ext;
  logic        out_free, slot_ok, at_end;
  logic        start_sweep, advance, push_out, push_last, pend_load, pend_drop;
  logic [31:0] pend_loc_ext, grp_ext, bank_ext, pend_row_ext;

  // input decode
  assign accept   = in_valid && in_ready;
  assign rank_ok  = 32'(in_rank) < ptrr_pkg::NUM_RANKS;
  assign addr_ok  = rank_ok && (grp_mode_r ?
                    (32'(in_bank_group) < ptrr_pkg::GROUPS_PER_RANK &&
                     32'(in_bank) < ptrr_pkg::BANKS_PER_GROUP) :
                    (32'(in_bank) < ptrr_pkg::BANKS_PER_RANK));
  assign loc_in   = grp_mode_r ?
                    32'(in_bank_group) * ptrr_pkg::BANKS_PER_GROUP + 32'(in_bank) :
                    32'(in_bank);
  assign flat_in  = 32'(in_rank) * ptrr_pkg::BANKS_PER_RANK + loc_in;
  assign flat_cur = 32'(rank_r) * ptrr_pkg::BANKS_PER_RANK + 32'(loc_r);
  assign draw_hit = {1'b0, in_random_draw} < thr_r;
  assign row_ext  = 32'(in_row);

  assign out_free = !out_valid_r || out_ready;
  assign slot_ok  = !pend_v_r || out_free;
  assign at_end   = loc_r == end_loc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptrr_pkg::ST_IDLE: begin
        if (accept && ((in_command == ptrr_pkg::CMD_RFM_ALL && rank_ok) ||
                       (in_command == ptrr_pkg::CMD_RFM_BANK && addr_ok))) begin
          state_nxt = ptrr_pkg::ST_SCAN;
        end
      end
      ptrr_pkg::ST_SCAN: begin
        if (rd_valid) begin
          state_nxt = ptrr_pkg::ST_READ;
        end else if (at_end) begin
          state_nxt = ptrr_pkg::ST_DONE;
        end
      end
      ptrr_pkg::ST_READ: begin
        if (slot_ok) begin
          state_nxt = at_end ? ptrr_pkg::ST_DONE : ptrr_pkg::ST_SCAN;
        end
      end
      ptrr_pkg::ST_DONE: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ptrr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptrr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready          = 1'b0;
    start_sweep       = 1'b0;
    advance           = 1'b0;
    push_out          = 1'b0;
    push_last         = 1'b0;
    pend_load         = 1'b0;
    pend_drop         = 1'b0;
    store_req.wr_en   = 1'b0;
    store_req.wr_addr = ptrr_pkg::IDX_W'(flat_in);
    store_req.wr_row  = row_ext[ptrr_pkg::ROW_BITS-1:0];
    store_req.clr_en  = 1'b0;
    store_req.rd_addr = ptrr_pkg::IDX_W'(flat_cur);
    loc_nxt           = '0;
    end_loc_nxt       = '0;
    unique case (state_r)
      ptrr_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        store_req.wr_en = accept && in_command == ptrr_pkg::CMD_ACT && addr_ok && draw_hit;
        start_sweep     = accept && ((in_command == ptrr_pkg::CMD_RFM_ALL && rank_ok) ||
                                     (in_command == ptrr_pkg::CMD_RFM_BANK && addr_ok));
        if (in_command == ptrr_pkg::CMD_RFM_ALL) begin
          loc_nxt     = '0;
          end_loc_nxt = ptrr_pkg::LOC_W'(ptrr_pkg::BANKS_PER_RANK - 1);
        end else begin
          loc_nxt     = ptrr_pkg::LOC_W'(loc_in);
          end_loc_nxt = ptrr_pkg::LOC_W'(loc_in);
        end
      end
      ptrr_pkg::ST_SCAN: begin
        store_req.clr_en = rd_valid;
        advance          = !rd_valid && !at_end;
      end
      ptrr_pkg::ST_READ: begin
        pend_load = slot_ok;
        push_out  = slot_ok && pend_v_r;
        advance   = slot_ok && !at_end;
      end
      ptrr_pkg::ST_DONE: begin
        push_out  = pend_v_r && out_free;
        push_last = 1'b1;
        pend_drop = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ptrr_pkg::ST_IDLE;
      thr_r      <= 17'h10000;
      grp_mode_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ptrr_pkg::REG_THRESHOLD:   thr_r      <= cfg_wdata;
          ptrr_pkg::REG_BANK_GROUPS: grp_mode_r <= cfg_wdata[0];
        endcase
      end
    end
  end

  // sweep position
  always_ff @(posedge clk) begin
    if (start_sweep) begin
      rank_r    <= in_rank;
      loc_r     <= loc_nxt;
      end_loc_r <= end_loc_nxt;
    end else if (advance) begin
      loc_r <= loc_r + ptrr_pkg::LOC_W'(1);
    end
  end

  // pending hit: held until the next hit or the end of the sweep decides last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (pend_load) begin
      pend_v_r <= 1'b1;
    end else if (pend_drop) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_rank_r <= rank_r;
      pend_loc_r  <= loc_r;
      pend_row_r  <= rd_row;
    end
  end

  assign pend_loc_ext = 32'(pend_loc_r);
  assign grp_ext      = grp_mode_r ? pend_loc_ext / ptrr_pkg::BANKS_PER_GROUP : 32'd0;
  assign bank_ext     = grp_mode_r ? pend_loc_ext % ptrr_pkg::BANKS_PER_GROUP : pend_loc_ext;
  assign pend_row_ext = 32'(pend_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      out_rank_r <= pend_rank_r;
      out_grp_r  <= grp_ext[2:0];
      out_bank_r <= bank_ext[4:0];
      out_row_r  <= pend_row_ext[16:0];
      out_last_r <= push_last;
    end
  end

  ptrr_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .rd_valid (rd_valid),
    .rd_row   (rd_row)
  );

  assign out_valid          = out_valid_r;
  assign out_vrr_rank       = out_rank_r;
  assign out_vrr_bank_group = out_grp_r;
  assign out_vrr_bank       = out_bank_r;
  assign out_vrr_row        = out_row_r;
  assign out_last           = out_last_r;

endmodule

// File: rtl/ptrr_store.sv
// Per-bank sample store: valid flops cleared at reset plus a row memory
// with one write port and one registered read port. Uses ptrr_pkg.
module ptrr_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptrr_pkg::store_req_t          req,
  output logic                          rd_valid,
  output logic [ptrr_pkg::ROW_BITS-1:0] rd_row
);

  logic [ptrr_pkg::NUM_BANKS-1:0] valid_r;
  logic [ptrr_pkg::ROW_BITS-1:0]  row_mem [ptrr_pkg::NUM_BANKS];
  logic [ptrr_pkg::ROW_BITS-1:0]  rd_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        valid_r[req.rd_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      row_mem[req.wr_addr] <= req.wr_row;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= row_mem[req.rd_addr];
  end

  assign rd_valid = valid_r[req.rd_addr];
  assign rd_row   = rd_row_r;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for probabilistic_trr_row_sampler: directed and random
// DRAM command requests, checked against an internal per-bank sampling predictor.
// Depends on ptrr_pkg and the RTL top level only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_OTHER = 2'd3;
  localparam int SETTLE_CYCLES = 2 * ptrr_pkg::BANKS_PER_RANK + 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 30;

  typedef struct packed {
    logic        rank;
    logic [2:0]  grp;
    logic [4:0]  bank;
    logic [16:0] row;
    logic        last;
  } refresh_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_OTHER;
  logic        in_rank = 1'b0;
  logic [2:0]  in_bank_group = 3'd0;
  logic [4:0]  in_bank = 5'd0;
  logic [16:0] in_row = 17'd0;
  logic [15:0] in_random_draw = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_vrr_rank;
  logic [2:0]  out_vrr_bank_group;
  logic [4:0]  out_vrr_bank;
  logic [16:0] out_vrr_row;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = ptrr_pkg::REG_THRESHOLD;
  logic [16:0] cfg_wdata = 17'd0;

  logic                          bank_sampled [ptrr_pkg::NUM_BANKS];
  logic [ptrr_pkg::ROW_BITS-1:0] bank_row [ptrr_pkg::NUM_BANKS];
  logic [16:0]                   threshold_q;
  logic                          groups_q;
  refresh_t                      pending_refreshes [$];

  int errors = 0;
  int cycle_count = 0;
  int hold_off_count = 0;
  int hold_off_done = 0;
  bit idle_on = 1'b0;

  probabilistic_trr_row_sampler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_rank           (in_rank),
    .in_bank_group     (in_bank_group),
    .in_bank           (in_bank),
    .in_row            (in_row),
    .in_random_draw    (in_random_draw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vrr_rank      (out_vrr_rank),
    .out_vrr_bank_group(out_vrr_bank_group),
    .out_vrr_bank      (out_vrr_bank),
    .out_vrr_row       (out_vrr_row),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int flat_bank(int rank, int grp, int bank);
    if (rank >= ptrr_pkg::NUM_RANKS) return -1;
    if (groups_q) begin
      if (grp >= ptrr_pkg::GROUPS_PER_RANK || bank >= ptrr_pkg::BANKS_PER_GROUP) return -1;
      return rank * ptrr_pkg::BANKS_PER_RANK + grp * ptrr_pkg::BANKS_PER_GROUP + bank;
    end
    if (bank >= ptrr_pkg::BANKS_PER_RANK) return -1;
    return rank * ptrr_pkg::BANKS_PER_RANK + bank;
  endfunction

  function automatic void predict_refreshes(logic [1:0] cmd, logic rank, logic [2:0] grp,
                                            logic [4:0] bank, logic [16:0] row,
                                            logic [15:0] draw);
    int idx;
    int bank_in_rank;
    int hits [$];
    refresh_t r;
    idx = flat_bank(int'(rank), int'(grp), int'(bank));
    case (cmd)
      ptrr_pkg::CMD_ACT: begin
        if (idx >= 0 && {1'b0, draw} < threshold_q) begin
          bank_sampled[idx] = 1'b1;
          bank_row[idx] = row[ptrr_pkg::ROW_BITS-1:0];
        end
      end
      ptrr_pkg::CMD_RFM_ALL: begin
        if (int'(rank) < ptrr_pkg::NUM_RANKS) begin
          for (int i = 0; i < ptrr_pkg::BANKS_PER_RANK; i++) begin
            if (bank_sampled[int'(rank) * ptrr_pkg::BANKS_PER_RANK + i])
              hits.push_back(int'(rank) * ptrr_pkg::BANKS_PER_RANK + i);
          end
        end
      end
      ptrr_pkg::CMD_RFM_BANK: begin
        if (idx >= 0 && bank_sampled[idx]) hits.push_back(idx);
      end
      default: ;
    endcase
    foreach (hits[k]) begin
      bank_in_rank = hits[k] % ptrr_pkg::BANKS_PER_RANK;
      r.rank = 1'(hits[k] / ptrr_pkg::BANKS_PER_RANK);
      r.grp  = groups_q ? 3'(bank_in_rank / ptrr_pkg::BANKS_PER_GROUP) : 3'd0;
      r.bank = groups_q ? 5'(bank_in_rank % ptrr_pkg::BANKS_PER_GROUP) : 5'(bank_in_rank);
      r.row  = 17'(bank_row[hits[k]]);
      r.last = (k == hits.size() - 1);
      bank_sampled[hits[k]] = 1'b0;
      pending_refreshes.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    refresh_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_refreshes.size() == 0) begin
        errors++;
        $display({"%0t: unexpected refresh, expected none, actual rank %0d group %0d ",
                  "bank %0d row 0x%0h last %0d"},
                 $time, out_vrr_rank, out_vrr_bank_group, out_vrr_bank, out_vrr_row,
                 out_last);
      end else begin
        exp_r = pending_refreshes.pop_front();
        check_field("vrr_rank", exp_r.rank, out_vrr_rank);
        check_field("vrr_bank_group", exp_r.grp, out_vrr_bank_group);
        check_field("vrr_bank", exp_r.bank, out_vrr_bank);
        check_field("vrr_row", exp_r.row, out_vrr_row);
        check_field("last", exp_r.last, out_last);
      end
    end
  end

  always begin
    @(posedge clk);
    if (hold_off_done != hold_off_count) begin
      hold_off_done = hold_off_count;
      out_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(posedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d refreshes outstanding", $time, pending_refreshes.size());
    $display("status: fail");
    $finish;
  end

  task automatic send_command(logic [1:0] cmd, logic rank, logic [2:0] grp, logic [4:0] bank,
                              logic [16:0] row, logic [15:0] draw);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_rank        <= rank;
    in_bank_group  <= grp;
    in_bank        <= bank;
    in_row         <= row;
    in_random_draw <= draw;
    do @(posedge clk); while (!in_ready);
    predict_refreshes(cmd, rank, grp, bank, row, draw);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_refreshes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [16:0] threshold, logic groups);
    cfg_we    <= 1'b1;
    cfg_index <= ptrr_pkg::REG_THRESHOLD;
    cfg_wdata <= threshold;
    @(posedge clk);
    threshold_q = threshold;
    cfg_index <= ptrr_pkg::REG_BANK_GROUPS;
    cfg_wdata <= {16'd0, groups};
    @(posedge clk);
    groups_q = groups;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd0, 5'd0, 17'h00000, 16'hFFFF);
    send_command(ptrr_pkg::CMD_ACT, 1'b1, 3'd7, 5'd3, 17'h1FFFF, 16'h0000);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd5, 5'd31, 17'h12345, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_BANK, 1'b0, 3'd5, 5'd31, 17'h00000, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_BANK, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_BANK, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    send_command(CMD_OTHER, 1'b1, 3'd7, 5'd31, 17'h1FFFF, 16'hFFFF);
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b1, 3'd2, 5'd9, 17'h0F0F0, 16'h1234);
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    drain();
  endtask

  task automatic test_threshold_edges();
    write_config(17'd0, 1'b1);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd1, 5'd1, 17'h05A5A, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_BANK, 1'b0, 3'd1, 5'd1, 17'h00000, 16'h0000);
    drain();
    write_config(17'h1FFFF, 1'b1);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd2, 5'd2, 17'h0AAAA, 16'hFFFF);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd3, 5'd0, 17'h15555, 16'hFFFF);
    drain();
    write_config(17'd1, 1'b1);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd4, 5'd1, 17'h00777, 16'h0001);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd4, 5'd2, 17'h10001, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    drain();
  endtask

  task automatic test_bank_mode();
    write_config(17'h10000, 1'b0);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd6, 5'd31, 17'h1C3C3, 16'h8000);
    send_command(ptrr_pkg::CMD_ACT, 1'b1, 3'd0, 5'd5, 17'h03C3C, 16'h7FFF);
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b1, 3'd0, 5'd0, 17'h00000, 16'h0000);
    send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'd0, 5'd20, 17'h0BEEF, 16'h0000);
    drain();
    write_config(17'h10000, 1'b1);
    send_command(ptrr_pkg::CMD_RFM_BANK, 1'b0, 3'd5, 5'd0, 17'h00000, 16'h0000);
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    drain();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_config(17'h10000, 1'b1);
    hold_off_count++;
    for (int i = 0; i < ptrr_pkg::BANKS_PER_RANK; i++)
      send_command(ptrr_pkg::CMD_ACT, 1'b0, 3'(i / ptrr_pkg::BANKS_PER_GROUP),
                   5'(i % ptrr_pkg::BANKS_PER_GROUP), 17'($urandom), 16'($urandom));
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b0, 3'd0, 5'd0, 17'h00000, 16'h0000);
    for (int i = 0; i < 8; i++)
      send_command(ptrr_pkg::CMD_ACT, 1'b1, 3'(i), 5'(i % ptrr_pkg::BANKS_PER_GROUP),
                   17'($urandom), 16'($urandom));
    send_command(ptrr_pkg::CMD_RFM_ALL, 1'b1, 3'd0, 5'd0, 17'h00000, 16'h0000);
    drain();
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    logic [16:0] threshold;
    logic [1:0]  cmd;
    logic        rank;
    logic [2:0]  grp;
    logic [4:0]  bank;
    logic [16:0] row;
    logic [15:0] draw;
    for (int phase = 0; phase < 4; phase++) begin
      idle_on = (phase < 3);
      case ($urandom_range(0, 3))
        0: threshold = 17'h10000;
        1: threshold = 17'($urandom_range(1, 65536));
        2: threshold = 17'h08000;
        default: threshold = 17'($urandom_range(0, 131071));
      endcase
      write_config(threshold, 1'($urandom_range(0, 1)));
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        rank = 1'($urandom);
        grp  = 3'($urandom);
        bank = 5'($urandom);
        row  = 17'($urandom);
        draw = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
          bank = groups_q ? 5'($urandom_range(0, ptrr_pkg::BANKS_PER_GROUP - 1))
                          : 5'($urandom_range(0, ptrr_pkg::BANKS_PER_RANK - 1));
        if ($urandom_range(0, 7) == 0) draw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (pick < 55) cmd = ptrr_pkg::CMD_ACT;
        else if (pick < 75) cmd = ptrr_pkg::CMD_RFM_BANK;
        else if (pick < 85) cmd = ptrr_pkg::CMD_RFM_ALL;
        else cmd = CMD_OTHER;
        send_command(cmd, rank, grp, bank, row, draw);
        if (cmd != CMD_OTHER) counted++;
      end
      drain();
    end
  endtask

  initial begin
    foreach (bank_sampled[i]) bank_sampled[i] = 1'b0;
    foreach (bank_row[i]) bank_row[i] = '0;
    threshold_q = 17'h10000;
    groups_q = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_edges();
    test_bank_mode();
    test_backpressure();
    test_random_traffic();
    if (errors == 0 && pending_refreshes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
